// ===== rtl/core/tbha_pkg.sv =====
// Package for the token bucket hammer admission block.
// Holds register codes, reset values, verdict codes and shared structs.
// No dependencies.
`default_nettype none

package tbha_pkg;

    // Fixed-point fraction of the token level.
    localparam int unsigned TOKEN_FRAC = 10;
    localparam logic [25:0] TOKEN_ONE  = 26'd1024;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_RATE    = 3'd1;
    localparam logic [2:0] REG_BURST   = 3'd2;
    localparam logic [2:0] REG_MULT    = 3'd3;
    localparam logic [2:0] REG_SUSTAIN = 3'd4;
    localparam logic [2:0] REG_BAN_SEC = 3'd5;

    // Reset values of the registers.
    localparam logic        RST_ENABLE  = 1'b1;
    localparam logic [25:0] RST_RATE    = 26'd10240;
    localparam logic [15:0] RST_BURST   = 16'd20;
    localparam logic [7:0]  RST_MULT    = 8'd4;
    localparam logic [15:0] RST_SUSTAIN = 16'd5;
    localparam logic [19:0] RST_BAN_SEC = 20'd3600;

    // Verdict codes.
    localparam logic [1:0] VERDICT_ADMIT  = 2'd0;
    localparam logic [1:0] VERDICT_BANNED = 2'd1;
    localparam logic [1:0] VERDICT_EMPTY  = 2'd2;
    localparam logic [1:0] VERDICT_HAMMER = 2'd3;

    typedef struct packed {
        logic        enable;
        logic [25:0] rate;
        logic [15:0] burst;
        logic [7:0]  mult;
        logic [15:0] sustain;
        logic [19:0] ban_sec;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic add;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/tbha_if.sv =====
// Request and result channel interfaces of the admission block.
// No dependencies.
`default_nettype none

interface tbha_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  peer_slot;
    logic [31:0] time_now;
    modport source(output valid, output peer_slot, output time_now, input ready);
    modport sink(input valid, input peer_slot, input time_now, output ready);
endinterface

interface tbha_res_if;
    logic       valid;
    logic       ready;
    logic       allowed;
    logic       ban_created;
    logic [1:0] verdict;
    modport source(output valid, output allowed, output ban_created, output verdict,
                   input ready);
    modport sink(input valid, input allowed, input ban_created, input verdict,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tbha_regs.sv =====
// APB configuration registers of the admission block.
// Depends on tbha_pkg.
`default_nettype none

module tbha_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tbha_pkg::t_cfg     o_cfg
);

    tbha_pkg::t_cfg r_cfg;
    logic           wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable  <= tbha_pkg::RST_ENABLE;
            r_cfg.rate    <= tbha_pkg::RST_RATE;
            r_cfg.burst   <= tbha_pkg::RST_BURST;
            r_cfg.mult    <= tbha_pkg::RST_MULT;
            r_cfg.sustain <= tbha_pkg::RST_SUSTAIN;
            r_cfg.ban_sec <= tbha_pkg::RST_BAN_SEC;
        end else if (wr) begin
            unique case (paddr[4:2])
                tbha_pkg::REG_ENABLE:  r_cfg.enable  <= pwdata[0];
                tbha_pkg::REG_RATE:    r_cfg.rate    <= pwdata[25:0];
                tbha_pkg::REG_BURST:   r_cfg.burst   <= pwdata[15:0];
                tbha_pkg::REG_MULT:    r_cfg.mult    <= pwdata[7:0];
                tbha_pkg::REG_SUSTAIN: r_cfg.sustain <= pwdata[15:0];
                tbha_pkg::REG_BAN_SEC: r_cfg.ban_sec <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (paddr[4:2])
            tbha_pkg::REG_ENABLE:  prdata = {31'd0, r_cfg.enable};
            tbha_pkg::REG_RATE:    prdata = {6'd0, r_cfg.rate};
            tbha_pkg::REG_BURST:   prdata = {16'd0, r_cfg.burst};
            tbha_pkg::REG_MULT:    prdata = {24'd0, r_cfg.mult};
            tbha_pkg::REG_SUSTAIN: prdata = {16'd0, r_cfg.sustain};
            tbha_pkg::REG_BAN_SEC: prdata = {12'd0, r_cfg.ban_sec};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tbha_ctrl.sv =====
// Controller state machine of the admission block.
// Depends on tbha_pkg; drives the datapath through command structs.
`default_nettype none

module tbha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  tbha_pkg::t_dp_sts      i_sts,
    output tbha_pkg::t_dp_cmd      o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MLO   = 3'd2;
    localparam logic [2:0] ST_MHI   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MLO;
                end
            end
            ST_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tbha_dp.sv =====
// Datapath of the admission block: per-slot state memories, shared
// multiplier, hammer and bucket update, result register. Depends on tbha_pkg.
`default_nettype none

module tbha_dp #(
    parameter int unsigned PEER_SLOTS         = 256,
    parameter int unsigned TIME_FRACTION_BITS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  tbha_pkg::t_cfg         i_cfg,
    input  tbha_pkg::t_dp_cmd      i_cmd,
    output tbha_pkg::t_dp_sts      o_sts,
    input  wire logic [7:0]        i_peer_slot,
    input  wire logic [31:0]       i_time_now,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic                   o_allowed,
    output logic                   o_ban_created,
    output logic [1:0]             o_verdict
);

    localparam int unsigned AW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int unsigned SW = 32 - TIME_FRACTION_BITS;
    localparam int unsigned BW = 20 + TIME_FRACTION_BITS;

    // State memories, one entry per slot.
    logic [25:0]   mem_level [PEER_SLOTS];
    logic [31:0]   mem_last  [PEER_SLOTS];
    logic          mem_bst   [PEER_SLOTS];
    logic [SW-1:0] mem_cur   [PEER_SLOTS];
    logic [31:0]   mem_att   [PEER_SLOTS];
    logic [15:0]   mem_run   [PEER_SLOTS];
    logic          mem_hst   [PEER_SLOTS];
    logic [31:0]   mem_until [PEER_SLOTS];
    logic          mem_bact  [PEER_SLOTS];

    // Registered read data and request.
    logic [25:0]   r_level;
    logic [31:0]   r_last;
    logic          r_bst;
    logic [SW-1:0] r_cur;
    logic [31:0]   r_att;
    logic [15:0]   r_run;
    logic          r_hst;
    logic [31:0]   r_until;
    logic          r_bact;
    logic [AW-1:0] r_slot;
    logic [31:0]   r_now;

    logic [AW:0]   r_clr_cnt;
    logic [24:0]   r_thr;
    logic [41:0]   r_p_lo;
    logic [41:0]   r_p_hi;
    logic [26:0]   r_refill;

    logic          r_out_valid;
    logic          r_allowed;
    logic          r_ban_created;
    logic [1:0]    r_verdict;

    logic [AW-1:0] in_slot;
    logic [31:0]   elapsed;
    logic [15:0]   mul_op;
    logic [41:0]   mul_prod;
    logic [33:0]   thr_prod;
    logic [24:0]   thr_ceil;
    logic [57:0]   prod_sum;
    logic [57:0]   refill_full;

    logic          banned;
    logic [SW-1:0] sec;
    logic [SW-1:0] n_cur;
    logic [31:0]   n_att;
    logic [15:0]   n_run;
    logic          ban_new;
    logic [31:0]   n_until;
    logic [32:0]   until_sum;
    logic          busy;

    logic [25:0]   cap;
    logic [25:0]   base;
    logic [27:0]   lvl_sum;
    logic [25:0]   lvl_capped;
    logic [25:0]   n_level;
    logic          tok_ok;

    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // Slot index modulo the slot count, one restoring step per bit.
    function automatic logic [AW-1:0] slot_mod(input logic [7:0] slot);
        logic [7:0] rem;
        rem = slot;
        for (int i = 7; i >= 0; i--) begin
            if ((longint'(PEER_SLOTS) << i) <= longint'(rem)) begin
                rem = rem - 8'(longint'(PEER_SLOTS) << i);
            end
        end
        return AW'(rem);
    endfunction

    assign in_slot = slot_mod(i_peer_slot);

    // Busy-second threshold from configuration, kept registered.
    assign thr_prod = 34'(i_cfg.rate) * 34'(i_cfg.mult);
    assign thr_ceil = 25'((35'(thr_prod) + 35'd1023) >> tbha_pkg::TOKEN_FRAC);

    always_ff @(posedge i_clk) begin
        r_thr <= (thr_ceil == 25'd0) ? 25'd1 : thr_ceil;
    end

    // Clearing pass counter after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear && !o_sts.clear_done) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign o_sts.clear_done = (r_clr_cnt == (AW+1)'(PEER_SLOTS));
    assign o_sts.out_free   = !r_out_valid || i_res_ready;

    // Memory read on acceptance of a request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_level <= mem_level[in_slot];
            r_last  <= mem_last[in_slot];
            r_bst   <= mem_bst[in_slot];
            r_cur   <= mem_cur[in_slot];
            r_att   <= mem_att[in_slot];
            r_run   <= mem_run[in_slot];
            r_hst   <= mem_hst[in_slot];
            r_until <= mem_until[in_slot];
            r_bact  <= mem_bact[in_slot];
            r_slot  <= in_slot;
            r_now   <= i_time_now;
        end
    end

    // Elapsed time since the last refill, split over one shared multiplier.
    assign elapsed  = (r_bst && (r_now > r_last)) ? (r_now - r_last) : 32'd0;
    assign mul_op   = i_cmd.mul_hi ? elapsed[31:16] : elapsed[15:0];
    assign mul_prod = 42'(mul_op) * 42'(i_cfg.rate);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) r_p_lo <= mul_prod;
        if (i_cmd.mul_hi) r_p_hi <= mul_prod;
    end

    // Combine partial products; anything at or above 2^26 fills any bucket.
    assign prod_sum    = {r_p_hi, 16'd0} + 58'(r_p_lo);
    assign refill_full = prod_sum >> TIME_FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_refill <= (refill_full[57:26] != 32'd0) ? 27'h400_0000 : 27'(refill_full);
        end
    end

    // Ban test and hammer detector.
    assign banned    = r_bact && (r_now < r_until);
    assign sec       = r_now[31:TIME_FRACTION_BITS];
    assign busy      = ({1'b0, sec} == ({1'b0, r_cur} + 1'b1)) && (r_att >= 32'(r_thr));
    assign until_sum = 33'(r_now) + 33'(BW'(i_cfg.ban_sec) << TIME_FRACTION_BITS);

    always_comb begin
        n_cur   = r_cur;
        n_att   = r_att;
        n_run   = r_run;
        ban_new = 1'b0;
        if (!r_hst) begin
            n_cur = sec;
            n_att = 32'd1;
        end else if (sec == r_cur) begin
            n_att = (r_att == 32'hFFFF_FFFF) ? r_att : r_att + 32'd1;
        end else begin
            if (busy) begin
                n_run = (r_run == 16'hFFFF) ? r_run : r_run + 16'd1;
            end else begin
                n_run = 16'd0;
            end
            n_cur   = sec;
            n_att   = 32'd1;
            ban_new = (n_run >= i_cfg.sustain);
        end
    end

    assign n_until = ban_new ? (until_sum[32] ? 32'hFFFF_FFFF : until_sum[31:0]) : r_until;

    // Token bucket refill and spend.
    assign cap        = {i_cfg.burst[15:0], 10'd0};
    assign base       = r_bst ? r_level : cap;
    assign lvl_sum    = 28'(base) + 28'(r_refill);
    assign lvl_capped = (lvl_sum > 28'(cap)) ? cap : lvl_sum[25:0];
    assign tok_ok     = (lvl_capped >= tbha_pkg::TOKEN_ONE);
    assign n_level    = tok_ok ? (lvl_capped - tbha_pkg::TOKEN_ONE) : lvl_capped;

    // Memory write: clearing pass or state update.
    assign wr_en   = (i_cmd.clear && !o_sts.clear_done) ||
                     (i_cmd.commit && i_cfg.enable && !banned);
    assign wr_addr = i_cmd.clear ? r_clr_cnt[AW-1:0] : r_slot;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (i_cmd.clear) begin
                mem_level[wr_addr] <= '0;
                mem_last[wr_addr]  <= '0;
                mem_bst[wr_addr]   <= 1'b0;
                mem_cur[wr_addr]   <= '0;
                mem_att[wr_addr]   <= '0;
                mem_run[wr_addr]   <= '0;
                mem_hst[wr_addr]   <= 1'b0;
                mem_until[wr_addr] <= '0;
                mem_bact[wr_addr]  <= 1'b0;
            end else begin
                mem_level[wr_addr] <= ban_new ? r_level : n_level;
                mem_last[wr_addr]  <= ban_new ? r_last : r_now;
                mem_bst[wr_addr]   <= r_bst || !ban_new;
                mem_cur[wr_addr]   <= n_cur;
                mem_att[wr_addr]   <= n_att;
                mem_run[wr_addr]   <= n_run;
                mem_hst[wr_addr]   <= 1'b1;
                mem_until[wr_addr] <= n_until;
                mem_bact[wr_addr]  <= r_bact || ban_new;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (!i_cfg.enable) begin
                r_allowed     <= 1'b1;
                r_ban_created <= 1'b0;
                r_verdict     <= tbha_pkg::VERDICT_ADMIT;
            end else if (banned) begin
                r_allowed     <= 1'b0;
                r_ban_created <= 1'b0;
                r_verdict     <= tbha_pkg::VERDICT_BANNED;
            end else if (ban_new) begin
                r_allowed     <= 1'b0;
                r_ban_created <= 1'b1;
                r_verdict     <= tbha_pkg::VERDICT_HAMMER;
            end else begin
                r_allowed     <= tok_ok;
                r_ban_created <= 1'b0;
                r_verdict     <= tok_ok ? tbha_pkg::VERDICT_ADMIT : tbha_pkg::VERDICT_EMPTY;
            end
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_allowed     = r_allowed;
    assign o_ban_created = r_ban_created;
    assign o_verdict     = r_verdict;

endmodule

`default_nettype wire

// ===== rtl/core/token_bucket_hammer_admission.sv =====
// Top level of the token bucket hammer admission block.
// Depends on tbha_pkg, tbha_if, tbha_regs, tbha_ctrl and tbha_dp.
//
//   Channel   Dir  Moves
//   i_req     in   request: peer_slot, time_now
//   o_res     out  result: allowed, ban_created, verdict
//   APB       in   configuration writes and reads, six registers
//
// One request passes five steps (accept, two halves of the refill multiply
// on a shared 16x26 multiplier, partial-product add, update), bounded by the
// single read-modify-write of the per-slot state memories.
// After reset a clearing pass zeroes all PEER_SLOTS entries of the memories;
// no request is accepted until it ends. A stalled result holds the update
// step; the result register lets the next request in while a result waits.
`default_nettype none

module token_bucket_hammer_admission #(
    parameter int unsigned PEER_SLOTS         = 256,
    parameter int unsigned TIME_FRACTION_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tbha_req_if.sink         i_req,
    tbha_res_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    tbha_pkg::t_cfg    cfg;
    tbha_pkg::t_dp_cmd cmd;
    tbha_pkg::t_dp_sts sts;
    logic              req_ready;

    assign i_req.ready = req_ready;

    // Configuration registers.
    tbha_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer.
    tbha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // State memories and arithmetic.
    tbha_dp #(
        .PEER_SLOTS         (PEER_SLOTS),
        .TIME_FRACTION_BITS (TIME_FRACTION_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_peer_slot   (i_req.peer_slot),
        .i_time_now    (i_req.time_now),
        .o_res_valid   (o_res.valid),
        .i_res_ready   (o_res.ready),
        .o_allowed     (o_res.allowed),
        .o_ban_created (o_res.ban_created),
        .o_verdict     (o_res.verdict)
    );

endmodule

`default_nettype wire

// ===== tb/tbha_checker.sv =====
// Checker for the token bucket hammer admission block: watches the request and
// result channels and the configuration port, predicts each result and compares.
// Depends on tbha_pkg and tbha_if.
`timescale 1ns / 1ps

module tbha_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tbha_req_if              req,
    tbha_res_if              res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen,
    output int               o_bans_seen
);

    typedef struct packed {
        logic       allowed;
        logic       ban_created;
        logic [1:0] verdict;
    } t_verdict;

    // Shadow copy of the configuration.
    tbha_pkg::t_cfg cfg;

    // Shadow copy of the per-slot state.
    logic [25:0] level_q    [256];
    logic [31:0] refill_t_q [256];
    logic        bkt_on_q   [256];
    logic [21:0] sec_q      [256];
    logic [31:0] count_q    [256];
    logic [15:0] run_q      [256];
    logic        ham_on_q   [256];
    logic [31:0] ban_end_q  [256];
    logic        ban_on_q   [256];

    t_verdict expected_verdicts[$];

    // Works out the verdict for one request and updates the shadow state.
    function automatic t_verdict predict_verdict(input logic [7:0] slot,
                                                 input logic [31:0] now);
        t_verdict   v;
        logic [21:0] sec;
        logic [63:0] thr, ending, cap, lvl, elapsed;
        logic       busy;
        v = '{allowed: 1'b1, ban_created: 1'b0, verdict: tbha_pkg::VERDICT_ADMIT};
        sec = now[31:10];
        if (!cfg.enable) return v;
        if (ban_on_q[slot] && now < ban_end_q[slot]) begin
            v = '{allowed: 1'b0, ban_created: 1'b0, verdict: tbha_pkg::VERDICT_BANNED};
            return v;
        end
        // Hammer detector.
        if (!ham_on_q[slot]) begin
            ham_on_q[slot] = 1'b1;
            sec_q[slot] = sec;
            count_q[slot] = 32'd1;
        end else if (sec == sec_q[slot]) begin
            if (count_q[slot] != 32'hFFFF_FFFF) count_q[slot] = count_q[slot] + 1;
        end else begin
            thr = (64'(cfg.rate) * 64'(cfg.mult) + 64'd1023) >> 10;
            if (thr < 1) thr = 1;
            busy = (64'(sec) == 64'(sec_q[slot]) + 1) && (64'(count_q[slot]) >= thr);
            if (busy) begin
                if (run_q[slot] != 16'hFFFF) run_q[slot] = run_q[slot] + 1;
            end else begin
                run_q[slot] = '0;
            end
            sec_q[slot] = sec;
            count_q[slot] = 32'd1;
            if (run_q[slot] >= cfg.sustain) begin
                ending = 64'(now) + (64'(cfg.ban_sec) << 10);
                if (ending > 64'hFFFF_FFFF) ending = 64'hFFFF_FFFF;
                ban_end_q[slot] = ending[31:0];
                ban_on_q[slot] = 1'b1;
                v = '{allowed: 1'b0, ban_created: 1'b1, verdict: tbha_pkg::VERDICT_HAMMER};
                return v;
            end
        end
        // Token bucket.
        cap = 64'(cfg.burst) << 10;
        if (!bkt_on_q[slot]) begin
            bkt_on_q[slot] = 1'b1;
            level_q[slot] = cap[25:0];
            refill_t_q[slot] = now;
        end
        elapsed = (now > refill_t_q[slot]) ? 64'(now - refill_t_q[slot]) : 64'd0;
        lvl = 64'(level_q[slot]) + ((elapsed * 64'(cfg.rate)) >> 10);
        if (lvl > cap) lvl = cap;
        refill_t_q[slot] = now;
        if (lvl < 64'(tbha_pkg::TOKEN_ONE)) begin
            level_q[slot] = lvl[25:0];
            v = '{allowed: 1'b0, ban_created: 1'b0, verdict: tbha_pkg::VERDICT_EMPTY};
        end else begin
            level_q[slot] = 26'(lvl - 64'(tbha_pkg::TOKEN_ONE));
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            cfg <= '{enable: tbha_pkg::RST_ENABLE, rate: tbha_pkg::RST_RATE,
                     burst: tbha_pkg::RST_BURST, mult: tbha_pkg::RST_MULT,
                     sustain: tbha_pkg::RST_SUSTAIN, ban_sec: tbha_pkg::RST_BAN_SEC};
            for (int i = 0; i < 256; i++) begin
                level_q[i] = '0; refill_t_q[i] = '0; bkt_on_q[i] = 1'b0;
                sec_q[i] = '0; count_q[i] = '0; run_q[i] = '0;
                ham_on_q[i] = 1'b0; ban_end_q[i] = '0; ban_on_q[i] = 1'b0;
            end
            expected_verdicts.delete();
            o_fail_count <= 0;
            o_pending <= 0;
            o_results_seen <= 0;
            o_bans_seen <= 0;
        end else begin
            // Register writes.
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    tbha_pkg::REG_ENABLE:  cfg.enable  <= pwdata[0];
                    tbha_pkg::REG_RATE:    cfg.rate    <= pwdata[25:0];
                    tbha_pkg::REG_BURST:   cfg.burst   <= pwdata[15:0];
                    tbha_pkg::REG_MULT:    cfg.mult    <= pwdata[7:0];
                    tbha_pkg::REG_SUSTAIN: cfg.sustain <= pwdata[15:0];
                    tbha_pkg::REG_BAN_SEC: cfg.ban_sec <= pwdata[19:0];
                    default: ;
                endcase
            end
            // Accepted request.
            if (req.valid && req.ready)
                expected_verdicts.insert(expected_verdicts.size(),
                                         predict_verdict(req.peer_slot, req.time_now));
            // Accepted result.
            if (res.valid && res.ready) begin
                o_results_seen <= o_results_seen + 1;
                if (res.ban_created) o_bans_seen <= o_bans_seen + 1;
                if (expected_verdicts.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_verdicts[0];
                    expected_verdicts.delete(0);
                    if (res.allowed !== want.allowed || res.ban_created !== want.ban_created ||
                        res.verdict !== want.verdict) begin
                        if (res.allowed !== want.allowed)
                            $error("allowed: expected %0d, got %0d", want.allowed, res.allowed);
                        if (res.ban_created !== want.ban_created)
                            $error("ban_created: expected %0d, got %0d",
                                   want.ban_created, res.ban_created);
                        if (res.verdict !== want.verdict)
                            $error("verdict: expected %0d, got %0d", want.verdict, res.verdict);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_verdicts.size();
        end
    end
endmodule

// ===== tb/token_bucket_hammer_admission_test.sv =====
// Top of the testbench for the token bucket hammer admission block: clock,
// reset, configuration writes, request stimulus and the verdict.
// Depends on tbha_pkg, tbha_if, tbha_checker and the block itself.
`timescale 1ns / 1ps

module token_bucket_hammer_admission_test;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, results_seen, bans_seen;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          res_stall_on = 1'b1;
    logic [31:0] slot_clock [256];

    tbha_req_if req();
    tbha_res_if res();

    token_bucket_hammer_admission dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req.sink), .o_res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tbha_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_fail_count(fail_count),
        .o_pending(pending), .o_results_seen(results_seen), .o_bans_seen(bans_seen)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[token_bucket_hammer_admission] ERROR");
            $finish;
        end
    end

    // Result side: random stall bursts until the quiet tail.
    initial begin
        int gap;
        res.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (!quiet && res_stall_on) begin
                gap = $urandom_range(1, 7);
                res.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {index, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every outstanding result and for the block to settle.
    task automatic drain_results();
        @(posedge i_clk iff pending == 0);
        repeat (20) @(posedge i_clk);
    endtask

    // Sends one request, with an optional random gap first.
    task automatic send_request(input logic [7:0] slot, input logic [31:0] now);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        req.valid <= 1'b1; req.peer_slot <= slot; req.time_now <= now;
        @(posedge i_clk iff req.ready);
    endtask

    task automatic end_burst();
        req.valid <= 1'b0;
    endtask

    // Random traffic: mostly bursts of hammering on a few slots, with noise.
    task automatic random_traffic(input int count, input int slot_span);
        logic [7:0]  slot;
        logic [31:0] step;
        for (int n = 0; n < count; n++) begin
            slot = 8'($urandom_range(0, slot_span));
            case ($urandom_range(0, 9))
                0:       step = $urandom();
                1:       step = -32'($urandom_range(0, 3000));
                2, 3:    step = 32'($urandom_range(1000, 1100));
                default: step = 32'($urandom_range(0, 60));
            endcase
            if ($urandom_range(0, 40) == 0) slot = 8'($urandom());
            slot_clock[slot] = slot_clock[slot] + step;
            send_request(slot, slot_clock[slot]);
        end
        end_burst();
    endtask

    initial begin
        req.valid <= 1'b0; req.peer_slot <= '0; req.time_now <= '0;
        for (int i = 0; i < 256; i++) slot_clock[i] = 32'($urandom_range(0, 1 << 20));
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, two attempts a second over eight seconds
        // on one slot, and time going backwards.
        send_request(8'd0, 32'd0);
        send_request(8'd255, 32'hFFFF_FFFF);
        send_request(8'd255, 32'hFFFF_FFFF);
        send_request(8'd255, 32'd5);
        for (int s = 0; s < 8; s++)
            for (int k = 0; k < 2; k++) send_request(8'd7, 32'(s * 1024 + k));
        send_request(8'd7, 32'd8200);
        end_burst();
        drain_results();

        // Small bucket, aggressive hammer, zero-length ban, disabled path.
        write_register(tbha_pkg::REG_BURST, 32'd1);
        write_register(tbha_pkg::REG_RATE, 32'd0);
        write_register(tbha_pkg::REG_MULT, 32'd2);
        write_register(tbha_pkg::REG_SUSTAIN, 32'd1);
        write_register(tbha_pkg::REG_BAN_SEC, 32'd0);
        for (int k = 0; k < 4; k++) send_request(8'd9, 32'(k * 1024));
        end_burst();
        drain_results();
        write_register(tbha_pkg::REG_ENABLE, 32'd0);
        send_request(8'd9, 32'd9000);
        end_burst();
        drain_results();
        write_register(tbha_pkg::REG_ENABLE, 32'd1);

        // Random phases through several settings, extremes among them.
        write_register(tbha_pkg::REG_RATE, 32'd1024);
        write_register(tbha_pkg::REG_BURST, 32'd3);
        write_register(tbha_pkg::REG_SUSTAIN, 32'd2);
        write_register(tbha_pkg::REG_BAN_SEC, 32'd2);
        random_traffic(250, 7);
        drain_results();

        write_register(tbha_pkg::REG_RATE, 32'h3FF_FFFF);
        write_register(tbha_pkg::REG_BURST, 32'hFFFF);
        write_register(tbha_pkg::REG_MULT, 32'd255);
        write_register(tbha_pkg::REG_SUSTAIN, 32'hFFFF);
        write_register(tbha_pkg::REG_BAN_SEC, 32'hF_FFFF);
        random_traffic(150, 255);
        drain_results();

        // Random phase with defaults-like settings, under result back-pressure.
        write_register(tbha_pkg::REG_RATE, 32'd10240);
        write_register(tbha_pkg::REG_BURST, 32'd20);
        write_register(tbha_pkg::REG_MULT, 32'd2);
        write_register(tbha_pkg::REG_SUSTAIN, 32'd1);
        write_register(tbha_pkg::REG_BAN_SEC, 32'd1);
        random_traffic(250, 3);
        drain_results();

        // Final part with no idling on either side.
        quiet = 1'b1;
        random_traffic(250, 15);
        drain_results();

        $display("Ran %0d results, %0d hammer bans, across six register settings.",
                 results_seen, bans_seen);
        if (fail_count == 0)
            $display("[token_bucket_hammer_admission] OK");
        else
            $display("[token_bucket_hammer_admission] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/tbha_pkg.sv
rtl/core/tbha_if.sv
rtl/core/tbha_regs.sv
rtl/core/tbha_ctrl.sv
rtl/core/tbha_dp.sv
rtl/core/token_bucket_hammer_admission.sv
tb/tbha_checker.sv
tb/token_bucket_hammer_admission_test.sv
